FILE: rtl/csvft_pkg.sv
// shared types and constants of the csv field tokenizer
package csvft_pkg;

    // character codes
    localparam logic [7:0] QUOTE_CHAR    = 8'h22;
    localparam logic [7:0] NEWLINE_CHAR  = 8'h0A;
    localparam logic [7:0] CR_CHAR       = 8'h0D;
    localparam logic [7:0] DEFAULT_DELIM = 8'h2C;

    // token kinds
    localparam logic [1:0] KIND_CONTENT   = 2'd0;
    localparam logic [1:0] KIND_FIELD_END = 2'd1;
    localparam logic [1:0] KIND_ROW_END   = 2'd2;

    // register indexes
    localparam int unsigned REG_DELIMITER = 0;
    localparam int unsigned NUM_REGS      = 1;

    // result queue
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int unsigned PADDR_W = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [1:0] token_kind;
        logic [7:0] content_byte;
        logic       last_of_run;
    } out_item_t;

endpackage

FILE: rtl/csv_field_tokenizer_core.sv
// top level of the csv field tokenizer: input stage, parser and result queue
//
// Splits a byte stream into field content bytes, end-of-field and end-of-row
// tokens. One byte is taken per clock cycle while s_ready is high; each byte
// yields zero, one or two tokens. A byte is registered at acceptance, parsed
// in the next cycle and its tokens are written into a four-entry result queue
// at the end of that parse cycle. s_ready is low while the queue, counting the
// tokens of the byte under parse, has fewer than two free slots; a sink that
// takes one token per cycle keeps one byte per cycle flowing, and bytes that
// yield two tokens fill the queue until the sink catches up. The delimiter
// register (byte address 0, reset comma) is written over the APB port and
// should only be changed while no transaction is in flight.
module csv_field_tokenizer_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  csvft_pkg::in_item_t             s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output csvft_pkg::out_item_t            m_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [csvft_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import csvft_pkg::*;

    logic [7:0]  delimiter_reg;
    logic        stage_valid_reg;
    in_item_t    stage_reg;
    logic        inside_quotes_reg, inside_quotes_next;
    logic        quote_pending_reg, quote_pending_next;
    logic        field_content_reg, field_content_next;
    logic        row_fields_reg, row_fields_next;
    out_item_t   queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    logic        emit_a;
    logic [1:0]  kind_a;
    logic [7:0]  byte_a;
    logic        emit_end;
    logic [1:0]  n_push;
    out_item_t   res0, res1;
    logic        pop;
    logic        reg_hit;

    // configuration port
    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_DELIMITER[PADDR_W-3:0]);
    assign prdata  = reg_hit ? {24'd0, delimiter_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delimiter_reg <= DEFAULT_DELIM;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            delimiter_reg <= pwdata[7:0];
        end
    end

    // parse the staged byte against the current quoting state
    always_comb begin
        emit_a             = 1'b0;
        kind_a             = KIND_CONTENT;
        byte_a             = 8'd0;
        inside_quotes_next = inside_quotes_reg;
        quote_pending_next = quote_pending_reg;
        field_content_next = field_content_reg;
        row_fields_next    = row_fields_reg;
        emit_end           = 1'b0;

        if (quote_pending_reg && stage_reg.data_byte == QUOTE_CHAR) begin
            // doubled quote gives a literal quote
            quote_pending_next = 1'b0;
            emit_a             = 1'b1;
            byte_a             = QUOTE_CHAR;
            field_content_next = 1'b1;
        end else if (inside_quotes_reg && !quote_pending_reg) begin
            if (stage_reg.data_byte == QUOTE_CHAR) begin
                quote_pending_next = 1'b1;
            end else begin
                emit_a             = 1'b1;
                byte_a             = stage_reg.data_byte;
                field_content_next = 1'b1;
            end
        end else begin
            // unquoted, including the byte after a closing quote
            quote_pending_next = 1'b0;
            inside_quotes_next = 1'b0;
            if (stage_reg.data_byte == QUOTE_CHAR) begin
                inside_quotes_next = 1'b1;
            end else if (stage_reg.data_byte == delimiter_reg) begin
                emit_a             = 1'b1;
                kind_a             = KIND_FIELD_END;
                field_content_next = 1'b0;
                row_fields_next    = 1'b1;
            end else if (stage_reg.data_byte == NEWLINE_CHAR) begin
                emit_a             = 1'b1;
                kind_a             = KIND_ROW_END;
                field_content_next = 1'b0;
                row_fields_next    = 1'b0;
            end else if (stage_reg.data_byte != CR_CHAR) begin
                emit_a             = 1'b1;
                byte_a             = stage_reg.data_byte;
                field_content_next = 1'b1;
            end
        end

        // end of stream closes a non-empty row and clears the state
        if (stage_reg.end_of_input) begin
            emit_end           = field_content_next || row_fields_next;
            inside_quotes_next = 1'b0;
            quote_pending_next = 1'b0;
            field_content_next = 1'b0;
            row_fields_next    = 1'b0;
        end
    end

    // assemble up to two results
    always_comb begin
        res0 = '0;
        res1 = '0;
        if (emit_a) begin
            res0.token_kind   = kind_a;
            res0.content_byte = byte_a;
            res0.last_of_run  = !emit_end;
            res1.token_kind   = KIND_ROW_END;
            res1.last_of_run  = 1'b1;
        end else begin
            res0.token_kind   = KIND_ROW_END;
            res0.last_of_run  = 1'b1;
        end
        n_push = stage_valid_reg ? ({1'b0, emit_a} + {1'b0, emit_end}) : 2'd0;
    end

    // queue handshake
    assign pop        = m_valid && m_ready;
    assign m_valid    = (count_reg != '0);
    assign m_data     = queue_reg[rd_ptr_reg];
    assign count_next = count_reg + QCNT_W'(n_push) - QCNT_W'(pop);
    assign s_ready    = (count_reg + QCNT_W'(n_push)) <= QCNT_W'(QUEUE_DEPTH - 2);

    // input stage, parser state and queue control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg   <= 1'b0;
            inside_quotes_reg <= 1'b0;
            quote_pending_reg <= 1'b0;
            field_content_reg <= 1'b0;
            row_fields_reg    <= 1'b0;
            wr_ptr_reg        <= '0;
            rd_ptr_reg        <= '0;
            count_reg         <= '0;
        end else begin
            stage_valid_reg <= s_valid && s_ready;
            if (stage_valid_reg) begin
                inside_quotes_reg <= inside_quotes_next;
                quote_pending_reg <= quote_pending_next;
                field_content_reg <= field_content_next;
                row_fields_reg    <= row_fields_next;
            end
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(n_push);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            stage_reg <= s_data;
        end
        if (n_push != 2'd0) begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (n_push == 2'd2) begin
            queue_reg[wr_ptr_reg + 1'b1] <= res1;
        end
    end

endmodule

FILE: rtl/csvft_checker.sv
// port-level checks of the csv field tokenizer and their binding
module csvft_props (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  csvft_pkg::in_item_t             s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  csvft_pkg::out_item_t            m_data
);
    import csvft_pkg::*;

    // no token kind beyond row end
    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.token_kind == KIND_CONTENT ||
                     m_data.token_kind == KIND_FIELD_END ||
                     m_data.token_kind == KIND_ROW_END))
        else $error("token kind out of range");

    // markers carry no content byte
    a_marker_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.token_kind != KIND_CONTENT) |-> (m_data.content_byte == 8'd0))
        else $error("marker with nonzero content byte");

    // a waiting input transaction holds its payload
    a_in_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> (s_valid && $stable(s_data)))
        else $error("input changed while waiting");

    // a stalled transaction holds its payload
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");

    // no results out of nothing right after reset
    a_idle_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind csv_field_tokenizer_core csvft_props u_csvft_props (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
